// ===== hw/rtl/tcw_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the text console writer.
`default_nettype none

package tcw_pkg;

  // Screen geometry.
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);

  // Field widths of the words on the stream ports.
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int CELL_W   = 16;
  localparam int INDEX_W  = 11;
  localparam int LOC_W    = 11;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 32;

  // Character codes with special handling.
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;      // latch the input word
    logic read;         // read the requested cell
    logic glyph;        // write a glyph at the cursor and advance
    logic glyph_space;  // the glyph is a space instead of the input character
    logic newline;      // move the cursor to the next line
    logic backspace;    // step back and blank one cell
    logic copy;         // one step of the scroll copy
    logic clear;        // one step of the reset clearing pass
    logic blank;        // one step of blanking the bottom row
    logic load_out;     // load the output register
  } tcw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;
    logic is_newline;
    logic is_tab;
    logic is_backspace;
    logic scroll_needed;
    logic scan_last;
    logic copy_last;
    logic out_free;
  } tcw_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire                      re,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_datapath.sv =====
// Datapath of the text console writer: screen store, cursor, scan counter and output register.
`default_nettype none

module tcw_datapath (
  input  wire                         clk,
  input  wire                         rst,
  input  wire tcw_pkg::tcw_cmd_t      cmd,
  output tcw_pkg::tcw_stat_t          stat,
  input  wire                         cfg_we,
  input  wire [tcw_pkg::ATTR_W-1:0]   cfg_data,
  input  wire                         in_action,
  input  wire [tcw_pkg::CHAR_W-1:0]   in_char,
  input  wire [tcw_pkg::INDEX_W-1:0]  in_index,
  input  wire                         m_tready,
  output logic                        out_valid,
  output logic [tcw_pkg::CELL_W-1:0]  out_cell,
  output logic [tcw_pkg::LOC_W-1:0]   out_loc
);

  import tcw_pkg::*;

  logic [ATTR_W-1:0]  attr;
  logic               item_action;
  logic [CHAR_W-1:0]  item_char;
  logic [INDEX_W-1:0] item_index;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   col;
  logic [ADDR_W-1:0]  scan;
  logic               pend;
  logic [ADDR_W-1:0]  pend_addr;

  logic [ADDR_W-1:0]  cur_addr;
  logic               in_range;
  logic               at_last_col;
  logic               at_last_row;
  logic               advance_line;
  logic [CHAR_W-1:0]  glyph;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;

  assign cur_addr     = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  assign in_range     = 32'(item_index) < 32'(CELL_COUNT);
  assign at_last_col  = col == COL_W'(COLUMNS - 1);
  assign at_last_row  = row == ROW_W'(ROWS - 1);
  assign advance_line = (cmd.glyph && at_last_col) || cmd.newline;
  assign glyph        = cmd.glyph_space ? CH_SPACE : item_char;

  always_comb begin
    stat.is_read       = item_action;
    stat.is_newline    = item_char == CH_NEWLINE;
    stat.is_tab        = item_char == CH_TAB;
    stat.is_backspace  = item_char == CH_BACKSPACE;
    stat.scroll_needed = advance_line && at_last_row;
    stat.scan_last     = scan == ADDR_W'(CELL_COUNT - 1);
    stat.copy_last     = scan == ADDR_W'(CELL_COUNT - COLUMNS - 1);
    stat.out_free      = !out_valid || m_tready;
  end

  // Write port: the delayed scroll copy write never coincides with another command.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = {attr, CH_SPACE};
    if (pend) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr;
      ram_wdata = ram_rdata;
    end else if (cmd.clear) begin
      ram_we    = 1'b1;
      ram_waddr = scan;
      ram_wdata = BLANK_CELL;
    end else if (cmd.blank) begin
      ram_we    = 1'b1;
      ram_waddr = scan;
    end else if (cmd.glyph) begin
      ram_we    = 1'b1;
      ram_wdata = {attr, glyph};
    end else if (cmd.backspace && col != '0) begin
      ram_we    = 1'b1;
      ram_waddr = cur_addr - ADDR_W'(1);
    end
  end

  assign ram_re    = cmd.copy || (cmd.read && in_range);
  assign ram_raddr = cmd.copy ? scan + ADDR_W'(COLUMNS) : ADDR_W'(item_index);

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      attr      <= ATTR_RESET;
      row       <= '0;
      col       <= '0;
      scan      <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        attr <= cfg_data;
      end

      pend      <= cmd.copy;
      pend_addr <= scan;

      if (cmd.capture) begin
        item_action <= in_action;
        item_char   <= in_char;
        item_index  <= in_index;
      end

      if (advance_line) begin
        col <= '0;
        if (!at_last_row) begin
          row <= row + ROW_W'(1);
        end
      end else if (cmd.glyph) begin
        col <= col + COL_W'(1);
      end else if (cmd.backspace && col != '0) begin
        col <= col - COL_W'(1);
      end

      if (cmd.clear || cmd.copy || cmd.blank) begin
        if (stat.scan_last) begin
          scan <= '0;
        end else begin
          scan <= scan + ADDR_W'(1);
        end
      end

      if (cmd.load_out) begin
        out_valid <= 1'b1;
        out_cell  <= (item_action && in_range) ? ram_rdata : '0;
        out_loc   <= LOC_W'(cur_addr);
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_ctrl.sv =====
// Controller state machine of the text console writer.
`default_nettype none

module tcw_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     s_tvalid,
  output logic                    s_tready,
  input  wire tcw_pkg::tcw_stat_t stat,
  output tcw_pkg::tcw_cmd_t       cmd
);

  import tcw_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_TAB   = 3'd3;
  localparam logic [2:0] S_COPY  = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;
  localparam logic [2:0] S_BLANK = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] tab_left;
  logic [1:0] tab_left_next;

  assign s_tready = state == S_IDLE;

  always_comb begin
    cmd           = '0;
    state_next    = state;
    tab_left_next = tab_left;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.scan_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        tab_left_next = 2'd0;
        if (stat.is_read) begin
          cmd.read = 1'b1;
        end else if (stat.is_newline) begin
          cmd.newline = 1'b1;
        end else if (stat.is_backspace) begin
          cmd.backspace = 1'b1;
        end else begin
          cmd.glyph       = 1'b1;
          cmd.glyph_space = stat.is_tab;
          if (stat.is_tab) begin
            tab_left_next = 2'd3;
          end
        end
        if (stat.scroll_needed) begin
          state_next = S_COPY;
        end else if (tab_left_next != 2'd0) begin
          state_next = S_TAB;
        end else begin
          state_next = S_DONE;
        end
      end
      S_TAB: begin
        cmd.glyph       = 1'b1;
        cmd.glyph_space = 1'b1;
        tab_left_next   = tab_left - 2'd1;
        if (stat.scroll_needed) begin
          state_next = S_COPY;
        end else if (tab_left_next != 2'd0) begin
          state_next = S_TAB;
        end else begin
          state_next = S_DONE;
        end
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (stat.copy_last) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_next = S_BLANK;
      end
      S_BLANK: begin
        cmd.blank = 1'b1;
        if (stat.scan_last) begin
          state_next = (tab_left != 2'd0) ? S_TAB : S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      tab_left <= 2'd0;
    end else begin
      state    <= state_next;
      tab_left <= tab_left_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/text_console_writer.sv =====
// Top level of the text console writer: stream ports, controller and datapath.
//
// The block keeps a ROWS x COLUMNS screen of 16-bit cells in a RAM and a cursor.
// Each word on the input stream is one command: tuser selects put (0) or read
// (1), tdata carries the character and the cell index. Each command returns
// exactly one word on the output stream with the read cell (zero for a put)
// and the cursor location after the command.
// The user must write the attribute register through cfg_we/cfg_data only
// while idle; the block itself does not enforce this. A plain put or a read
// goes from acceptance to the output register through capture, execute and
// load, and no new word is taken until the load. A tab writes four cells. A
// put that moves past the last row scrolls the screen: the RAM's single read
// and write ports move one cell a cycle, copying each row up by one, then a
// flush step, then blanking the bottom row.
// After reset the block clears all CELL_COUNT cells (2000 at 80x25) of the RAM
// to grey blanks, one cell a cycle, and accepts no word during that pass.
// The output register lets the next word be accepted while a result waits;
// if the receiver stalls, the following result waits inside the block and
// no further word is accepted until the pending one is taken.
`default_nettype none

module text_console_writer (
  input  wire                          clk,
  input  wire                          rst,
  // Input stream. tdata: char_code [7:0], cell_index [18:8], zeros above.
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire [tcw_pkg::S_DATA_W-1:0]  s_tdata,
  // tuser: action [0].
  input  wire [0:0]                    s_tuser,
  // Output stream. tdata: cell_data [15:0], cursor_location [26:16], zeros above.
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [tcw_pkg::M_DATA_W-1:0] m_tdata,
  // Attribute register write.
  input  wire                          cfg_we,
  input  wire [tcw_pkg::ATTR_W-1:0]    cfg_data
);

  import tcw_pkg::*;

  tcw_cmd_t          cmd;
  tcw_stat_t         stat;
  logic [CELL_W-1:0] out_cell;
  logic [LOC_W-1:0]  out_loc;

  // The controller sequences each command; the datapath owns all storage.
  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcw_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_action  (s_tuser[0]),
    .in_char    (s_tdata[CHAR_W-1:0]),
    .in_index   (s_tdata[CHAR_W+INDEX_W-1:CHAR_W]),
    .m_tready   (m_tready),
    .out_valid  (m_tvalid),
    .out_cell   (out_cell),
    .out_loc    (out_loc)
  );

  // Pack the result fields, lowest field first, zero fill to the word width.
  assign m_tdata = {{(M_DATA_W - LOC_W - CELL_W){1'b0}}, out_loc, out_cell};

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the text console writer: stream traffic, console predictor, checks.
`timescale 1ns / 1ps

module tb_top;
  import tcw_pkg::*;

  // Action selector carried in s_tuser.
  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Cycles the sender stays quiet after the last result before it touches the
  // attribute register or resumes after a pause. Every word returns exactly one
  // result, so the block is idle once the counts match; this is only margin.
  localparam int SETTLE_CYCLES = 8;
  // Length of the long receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES   = 200;
  // Cycles to watch the output after the last expected word has arrived.
  localparam int TAIL_CYCLES   = 50;
  // Random words per traffic phase.
  localparam int PHASE_WORDS   = 220;

  // What the sender does with one entry of its feed.
  typedef enum logic [2:0] {
    FEED_WORD,   // offer one word on the input stream
    FEED_CFG,    // wait for idle, then write the attribute register
    FEED_DRAIN,  // wait until every result has come back
    FEED_HOLD,   // start the long receiver hold-off
    FEED_IDLE    // switch random idling on or off for both sides
  } feed_kind_t;

  typedef struct {
    feed_kind_t           kind;
    logic                 action;
    logic [CHAR_W-1:0]    code;
    logic [INDEX_W-1:0]   index;
    logic [ATTR_W-1:0]    value;
  } feed_entry_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [LOC_W-1:0]  loc;
  } console_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  cfg_we = 1'b0;
  logic [ATTR_W-1:0]     cfg_data = '0;

  text_console_writer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // char_code [7:0], cell_index [18:8]
    .s_tuser  (s_tuser),   // action [0]
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // cell_data [15:0], cursor_location [26:16]
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Console predictor. It keeps its own copy of the screen, the cursor and the
  // attribute, and is stepped once for every word the block accepts.
  // ---------------------------------------------------------------------------
  logic [CELL_W-1:0] shadow_screen [0:CELL_COUNT-1];
  int                shadow_row;
  int                shadow_col;
  logic [ATTR_W-1:0] shadow_attr;
  int                scroll_count;
  int                put_count;
  int                read_count;
  int                cfg_count;

  // Scroll the screen up by one row and blank the bottom row in the current
  // attribute. The cursor stays on the last row at column 0.
  function automatic void shift_screen_up();
    for (int i = 0; i + COLUMNS < CELL_COUNT; i++) begin
      shadow_screen[i] = shadow_screen[i + COLUMNS];
    end
    for (int i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++) begin
      shadow_screen[i] = {shadow_attr, CH_SPACE};
    end
    shadow_col = 0;
    scroll_count++;
  endfunction

  function automatic void advance_line();
    shadow_col = 0;
    shadow_row++;
    if (shadow_row >= ROWS) begin
      shadow_row = ROWS - 1;
      shift_screen_up();
    end
  endfunction

  // Write one glyph at the cursor and step right, wrapping at the line end.
  function automatic void place_glyph(logic [CHAR_W-1:0] glyph);
    shadow_screen[shadow_row * COLUMNS + shadow_col] = {shadow_attr, glyph};
    shadow_col++;
    if (shadow_col >= COLUMNS) begin
      advance_line();
    end
  endfunction

  function automatic console_result_t predict_console(logic action, logic [CHAR_W-1:0] code,
                                                      logic [INDEX_W-1:0] index);
    console_result_t res;
    res.cell_data = '0;
    if (action == ACT_PUT) begin
      put_count++;
      if (code == CH_NEWLINE) begin
        advance_line();
      end else if (code == CH_TAB) begin
        // A tab is four ordinary spaces; any of them may wrap or scroll.
        repeat (4) place_glyph(CH_SPACE);
      end else if (code == CH_BACKSPACE) begin
        // At column 0 a backspace leaves everything as it is.
        if (shadow_col > 0) begin
          shadow_col--;
          shadow_screen[shadow_row * COLUMNS + shadow_col] = {shadow_attr, CH_SPACE};
        end
      end else begin
        place_glyph(code);
      end
    end else begin
      read_count++;
      // Indexes past the screen read as zero.
      if (index < CELL_COUNT) begin
        res.cell_data = shadow_screen[index];
      end
    end
    res.loc = LOC_W'(shadow_row * COLUMNS + shadow_col);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared bookkeeping between the sender, the receiver and the end of run.
  // ---------------------------------------------------------------------------
  feed_entry_t     feed [$];
  console_result_t expected_results [$];
  int              words_sent    = 0;   // written by the driver only
  int              words_checked = 0;   // written by the monitor only
  int              mismatch_count = 0;
  logic            idle_enabled = 1'b1;
  logic            hold_start = 1'b0;
  int              hold_left = 0;
  int              gap_left = 0;
  int              stall_left = 0;
  int              quiet_cycles = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 40) begin
      $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // Each side waits this many cycles after every word while idling is on.
  function automatic int draw_wait();
    return idle_enabled ? int'($urandom_range(0, 10)) : 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. It pops the feed one entry at a time. Words are offered until the
  // handshake completes; the prediction is made at the accepting edge so the
  // expected results stay in acceptance order. Register writes and pauses only
  // go ahead once every issued word has returned its result and the sender has
  // then stayed quiet for the SETTLE_CYCLES margin.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : word_driver
    logic                valid_n;
    logic                we_n;
    logic                hold_n;
    logic                idle_n;
    logic [ATTR_W-1:0]   attr_n;
    logic [S_DATA_W-1:0] data_n;
    logic [0:0]          user_n;
    int                  gap;
    int                  quiet;
    feed_entry_t         head;

    valid_n = s_tvalid;
    we_n    = 1'b0;
    hold_n  = 1'b0;
    idle_n  = idle_enabled;
    attr_n  = cfg_data;
    data_n  = s_tdata;
    user_n  = s_tuser;
    gap     = gap_left;
    quiet   = quiet_cycles;
    if (rst) begin
      valid_n = 1'b0;
      gap     = 0;
      quiet   = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(predict_console(s_tuser[0], s_tdata[CHAR_W-1:0],
                                                   s_tdata[CHAR_W +: INDEX_W]));
        words_sent <= words_sent + 1;
        valid_n = 1'b0;
        gap     = draw_wait();
      end
      // The block is idle when every issued word has come back.
      if (words_sent == words_checked && !s_tvalid) begin
        quiet++;
      end else begin
        quiet = 0;
      end
      if (!valid_n) begin
        if (gap > 0) begin
          gap--;
        end else if (feed.size() != 0) begin
          head = feed[0];
          case (head.kind)
            FEED_WORD: begin
              valid_n = 1'b1;
              data_n  = {{(S_DATA_W - CHAR_W - INDEX_W){1'b0}}, head.index, head.code};
              user_n  = head.action;
              void'(feed.pop_front());
            end
            FEED_CFG: begin
              if (quiet >= SETTLE_CYCLES) begin
                we_n        = 1'b1;
                attr_n      = head.value;
                shadow_attr = head.value;
                cfg_count++;
                quiet = 0;
                void'(feed.pop_front());
              end
            end
            FEED_DRAIN: begin
              if (quiet >= SETTLE_CYCLES) begin
                void'(feed.pop_front());
              end
            end
            FEED_HOLD: begin
              hold_n = 1'b1;
              void'(feed.pop_front());
            end
            default: begin
              idle_n = head.value[0];
              void'(feed.pop_front());
            end
          endcase
        end
      end
    end
    s_tvalid     <= valid_n;
    s_tdata      <= data_n;
    s_tuser      <= user_n;
    cfg_we       <= we_n;
    cfg_data     <= attr_n;
    hold_start   <= hold_n;
    idle_enabled <= idle_n;
    gap_left     <= gap;
    quiet_cycles <= quiet;
  end

  // Long receiver hold-off, counted here so the monitor only sees a level.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Every accepted word is compared with the oldest expectation, field
  // by field. After each word the receiver draws a stall, and it stays stalled
  // while the long hold-off runs.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    logic            ready_n;
    int              stall;
    console_result_t want;

    ready_n = m_tready;
    stall   = stall_left;
    if (rst) begin
      ready_n = 1'b0;
      stall   = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word", m_tdata, '0);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[CELL_W-1:0] !== want.cell_data) begin
            report_mismatch("cell_data", m_tdata[CELL_W-1:0], want.cell_data);
          end
          if (m_tdata[CELL_W +: LOC_W] !== want.loc) begin
            report_mismatch("cursor_location", m_tdata[CELL_W +: LOC_W], want.loc);
          end
          words_checked <= words_checked + 1;
        end
        stall = draw_wait();
      end
      if (stall > 0) begin
        stall--;
        ready_n = 1'b0;
      end else begin
        ready_n = (hold_left == 0);
      end
    end
    m_tready   <= ready_n;
    stall_left <= stall;
  end

  // ---------------------------------------------------------------------------
  // Stimulus. The whole feed is built at time zero; the driver works through it.
  // ---------------------------------------------------------------------------
  int words_queued = 0;

  task automatic add_word(input logic action, input logic [CHAR_W-1:0] code,
                          input logic [INDEX_W-1:0] index);
    feed.push_back('{FEED_WORD, action, code, index, '0});
    words_queued++;
  endtask

  // The unused field of each word is random so that every bit of it moves.
  task automatic add_put(input logic [CHAR_W-1:0] code);
    add_word(ACT_PUT, code, INDEX_W'($urandom_range(0, 2047)));
  endtask

  task automatic add_read(input int index);
    add_word(ACT_READ, CHAR_W'($urandom_range(0, 255)), INDEX_W'(index));
  endtask

  task automatic add_entry(input feed_kind_t kind, input logic [ATTR_W-1:0] value);
    feed.push_back('{kind, ACT_PUT, '0, '0, value});
  endtask

  function automatic logic [CHAR_W-1:0] printable();
    return CHAR_W'($urandom_range(8'h20, 8'h7E));
  endfunction

  // Most reads land on the bottom row, where text keeps arriving once the
  // screen scrolls; a few fall past the end of the screen.
  function automatic int read_target();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range((ROWS - 1) * COLUMNS, CELL_COUNT - 1);
      4, 5, 6:    return $urandom_range(0, CELL_COUNT - 1);
      7:          return $urandom_range(CELL_COUNT, 2047);
      default: begin
        case ($urandom_range(0, 3))
          0:       return 0;
          1:       return COLUMNS - 1;
          2:       return (ROWS - 1) * COLUMNS;
          default: return CELL_COUNT - 1;
        endcase
      end
    endcase
  endfunction

  // Random console traffic: mostly lines of text with newlines, some lines
  // that run past the line end and finish with a tab, editing bursts of up to
  // four characters then up to seven backspaces, reads, and a share of raw noise.
  task automatic add_random_traffic(input int count);
    int stop_at;
    int pick;
    stop_at = words_queued + count;
    while (words_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        repeat ($urandom_range(0, 30)) add_put(printable());
        if ($urandom_range(0, 4) != 0) add_put(CH_NEWLINE);
      end else if (pick < 46) begin
        repeat ($urandom_range(COLUMNS - 6, COLUMNS + 4)) add_put(printable());
        add_put(CH_TAB);
      end else if (pick < 52) begin
        repeat ($urandom_range(1, 4)) add_put(CH_NEWLINE);
      end else if (pick < 64) begin
        repeat ($urandom_range(0, 4)) add_put(printable());
        repeat ($urandom_range(1, 7)) add_put(CH_BACKSPACE);
        if ($urandom_range(0, 1)) add_put(CH_TAB);
      end else if (pick < 84) begin
        repeat ($urandom_range(1, 4)) add_read(read_target());
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1)) begin
            add_put(CHAR_W'($urandom_range(0, 255)));
          end else begin
            add_read($urandom_range(0, 2047));
          end
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < CELL_COUNT; i++) begin
      shadow_screen[i] = BLANK_CELL;
    end
    shadow_row   = 0;
    shadow_col   = 0;
    shadow_attr  = ATTR_RESET;
    scroll_count = 0;
    put_count    = 0;
    read_count   = 0;
    cfg_count    = 0;

    // Directed opening: reset contents at both ends of the screen and past it,
    // glyph extremes, backspace in mid line and at column 0, a tab, a newline,
    // and puts under both extreme attributes.
    add_read(0);
    add_read(CELL_COUNT - 1);
    add_read(CELL_COUNT);
    add_read(2047);
    add_put(8'h41);
    add_put(8'h00);
    add_put(8'hFF);
    add_put(8'h7F);
    add_put(CH_BACKSPACE);
    add_read(3);
    add_put(CH_TAB);
    add_read(2);
    add_put(CH_NEWLINE);
    add_put(CH_BACKSPACE);
    add_entry(FEED_CFG, 8'h00);
    add_put(8'h5A);
    add_entry(FEED_CFG, 8'hFF);
    add_put(8'h5A);
    add_put(CH_BACKSPACE);
    add_read(COLUMNS);
    add_read(COLUMNS + 1);
    add_read(5);

    // Random phases, each under its own attribute. Phase 1 runs without any
    // idling; phase 2 opens with the long receiver hold-off while the sender
    // keeps offering words back to back; phase 3 pauses the sender midway
    // until every result is in.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       add_entry(FEED_CFG, 8'h1F);
        1:       add_entry(FEED_CFG, 8'h00);
        2:       add_entry(FEED_CFG, 8'hFF);
        3:       add_entry(FEED_CFG, ATTR_W'($urandom_range(1, 254)));
        default: add_entry(FEED_CFG, 8'h70);
      endcase
      add_entry(FEED_IDLE, (phase == 1) ? 8'h00 : 8'h01);
      if (phase == 2) begin
        add_entry(FEED_IDLE, 8'h00);
        add_entry(FEED_HOLD, 8'h00);
        repeat (30) add_put(printable());
        add_entry(FEED_IDLE, 8'h01);
      end
      if (phase == 3) begin
        add_random_traffic(PHASE_WORDS / 2);
        add_entry(FEED_DRAIN, 8'h00);
        add_random_traffic(PHASE_WORDS / 2);
      end else begin
        add_random_traffic(PHASE_WORDS);
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Wait for the feed to empty and every result to come back, then watch
    // the output a little longer for stray words.
    while (feed.size() != 0 || s_tvalid || words_sent != words_checked) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch("results never delivered", expected_results.size(), 0);
    end

    $display("Checked %0d words: %0d puts, %0d reads, %0d scrolls, %0d attribute writes.",
             words_checked, put_count, read_count, scroll_count, cfg_count);
    $display("Mismatches: %0d.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit, far above the slowest expected run: the reset clearing pass,
  // about 1100 words with the longest stalls on both sides, and a full-screen
  // scroll for every single word.
  initial begin
    #100ms;
    $display("Timed out with %0d words sent and %0d checked.", words_sent, words_checked);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== text_console_writer.f =====
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/tcw_datapath.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/text_console_writer.sv
test/tb_top.sv
